### rtl/overwriting_ring_with_offset_lookup_assert.svh
// Assertion helpers, clocked on clk, off during reset.
`ifndef OVERWRITING_RING_WITH_OFFSET_LOOKUP_ASSERT_SVH
`define OVERWRITING_RING_WITH_OFFSET_LOOKUP_ASSERT_SVH

// Same-cycle implication.
`define ORWOL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ORWOL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/orwol_pkg.sv
package orwol_pkg;

  localparam int SLOTS      = 16;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int HANDLE_W   = 32;
  localparam int SIZE_W     = 16;
  localparam int OFFSET_W   = 24;
  localparam int SLOT_IDX_W = 4;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 56;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_FIND = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_FETCH,
    ST_CHECK,
    ST_RESP
  } st_t;

  typedef struct packed {
    logic                we;
    idx_t                addr;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
  } mem_wr_t;

  typedef struct packed {
    logic                  found;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [HANDLE_W-1:0]   found_handle;
    logic [SIZE_W-1:0]     byte_offset;
  } res_t;

  function automatic idx_t next_slot(idx_t p);
    return (p == idx_t'(SLOTS - 1)) ? '0 : p + idx_t'(1);
  endfunction

endpackage

### rtl/orwol_store.sv
module orwol_store (
  input  logic                            clk,
  input  orwol_pkg::mem_wr_t              wr,
  input  orwol_pkg::idx_t                 rd_addr,
  output logic [orwol_pkg::HANDLE_W-1:0]  rd_handle,
  output logic [orwol_pkg::SIZE_W-1:0]    rd_size
);

  logic [orwol_pkg::HANDLE_W-1:0] handle_mem_r [orwol_pkg::SLOTS];
  logic [orwol_pkg::SIZE_W-1:0]   size_mem_r   [orwol_pkg::SLOTS];
  logic [orwol_pkg::HANDLE_W-1:0] rd_handle_r;
  logic [orwol_pkg::SIZE_W-1:0]   rd_size_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      handle_mem_r[wr.addr] <= wr.handle;
      size_mem_r[wr.addr]   <= wr.size;
    end
    rd_handle_r <= handle_mem_r[rd_addr];
    rd_size_r   <= size_mem_r[rd_addr];
  end

  assign rd_handle = rd_handle_r;
  assign rd_size   = rd_size_r;

endmodule

### rtl/orwol_seq.sv
`include "overwriting_ring_with_offset_lookup_assert.svh"

module orwol_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic [orwol_pkg::HANDLE_W-1:0]  in_handle,
  input  logic [orwol_pkg::SIZE_W-1:0]    in_size,
  input  logic [orwol_pkg::OFFSET_W-1:0]  in_offset,
  output orwol_pkg::mem_wr_t              mem_wr,
  output orwol_pkg::idx_t                 rd_addr,
  input  logic [orwol_pkg::HANDLE_W-1:0]  rd_handle,
  input  logic [orwol_pkg::SIZE_W-1:0]    rd_size,
  output logic                            res_valid,
  input  logic                            res_ready,
  output orwol_pkg::res_t                 res
);

  orwol_pkg::st_t state_r, state_nxt;

  logic [orwol_pkg::HANDLE_W-1:0] handle_r;
  logic [orwol_pkg::SIZE_W-1:0]   size_r;
  logic [orwol_pkg::OFFSET_W-1:0] off_r;
  orwol_pkg::idx_t                idx_r;
  orwol_pkg::idx_t                cnt_r;
  orwol_pkg::idx_t                wr_ptr_r;
  orwol_pkg::idx_t                rd_ptr_r;
  logic [orwol_pkg::SLOTS-1:0]    occ_r;
  orwol_pkg::res_t                res_r;

  logic                           empty;
  logic                           fits;
  logic                           last;
  logic                           stop;
  logic                           full;
  logic [orwol_pkg::OFFSET_W-1:0] size_ext;
  logic [orwol_pkg::OFFSET_W-1:0] diff;

  // shared compare/subtract unit, one slot per cycle
  assign size_ext = orwol_pkg::OFFSET_W'(rd_size);
  assign empty    = !occ_r[idx_r] || (rd_size == '0);
  assign fits     = off_r < size_ext;
  assign diff     = off_r - size_ext;
  assign last     = cnt_r == orwol_pkg::idx_t'(orwol_pkg::SLOTS - 1);
  assign stop     = empty || fits || last;
  assign full     = occ_r[rd_ptr_r] && (rd_ptr_r == wr_ptr_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      orwol_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_mode == orwol_pkg::MODE_ADD) ? orwol_pkg::ST_ADD
                                                       : orwol_pkg::ST_FETCH;
        end
      end
      orwol_pkg::ST_ADD:   state_nxt = orwol_pkg::ST_RESP;
      orwol_pkg::ST_FETCH: state_nxt = orwol_pkg::ST_CHECK;
      orwol_pkg::ST_CHECK: begin
        if (stop) begin
          state_nxt = orwol_pkg::ST_RESP;
        end
      end
      orwol_pkg::ST_RESP: begin
        if (res_ready) begin
          state_nxt = orwol_pkg::ST_IDLE;
        end
      end
      default: state_nxt = orwol_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == orwol_pkg::ST_IDLE);
    res_valid = (state_r == orwol_pkg::ST_RESP);
    res       = res_r;
    // prefetch the next slot while the current one is checked
    rd_addr   = (state_r == orwol_pkg::ST_CHECK) ? orwol_pkg::next_slot(idx_r) : idx_r;
    mem_wr.we     = (state_r == orwol_pkg::ST_ADD);
    mem_wr.addr   = wr_ptr_r;
    mem_wr.handle = handle_r;
    mem_wr.size   = size_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= orwol_pkg::ST_IDLE;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == orwol_pkg::ST_ADD) begin
        occ_r[wr_ptr_r] <= (handle_r != '0);
        wr_ptr_r        <= orwol_pkg::next_slot(wr_ptr_r);
        if (full) begin
          rd_ptr_r <= orwol_pkg::next_slot(rd_ptr_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == orwol_pkg::ST_IDLE && in_valid) begin
      handle_r <= in_handle;
      size_r   <= in_size;
      off_r    <= in_offset;
      idx_r    <= rd_ptr_r;
      cnt_r    <= '0;
    end
    if (state_r == orwol_pkg::ST_ADD) begin
      res_r <= '0;
    end
    if (state_r == orwol_pkg::ST_CHECK) begin
      priority if (empty) begin
        res_r <= '0;
      end else if (fits) begin
        res_r.found        <= 1'b1;
        res_r.slot_index   <= orwol_pkg::SLOT_IDX_W'(idx_r);
        res_r.found_handle <= rd_handle;
        res_r.byte_offset  <= off_r[orwol_pkg::SIZE_W-1:0];
      end else if (last) begin
        res_r <= '0;
      end else begin
        off_r <= diff;
        idx_r <= orwol_pkg::next_slot(idx_r);
        cnt_r <= cnt_r + orwol_pkg::idx_t'(1);
      end
    end
  end

  `ORWOL_ASSERT_NOW(a_idle_no_res, state_r == orwol_pkg::ST_IDLE, !res_valid, "result while idle")
  `ORWOL_ASSERT_NEXT(a_add_moves_wr, state_r == orwol_pkg::ST_ADD, wr_ptr_r != $past(wr_ptr_r), "write pointer stuck")
  `ORWOL_ASSERT_NEXT(a_rd_only_on_add, state_r != orwol_pkg::ST_ADD, $stable(rd_ptr_r), "read pointer moved")
  `ORWOL_ASSERT_NOW(a_found_occupied, res_valid && res.found, res.found_handle != '0, "hit on empty slot")

endmodule

### rtl/overwriting_ring_with_offset_lookup.sv
// Ring of SLOTS entries (handle, byte size) that overwrites the oldest entry
// when full, with lookup of a byte offset across all stored entries. One item
// at a time: an add goes from acceptance through ST_ADD to the result; a find
// goes through ST_FETCH and then one ST_CHECK step per slot visited, at most
// SLOTS, walked by a single compare/subtract unit on the single-read-port slot
// memory one entry per cycle from the oldest. The result sits in an output
// register, so the next item is taken while it waits. Slots are marked empty
// by reset at once; there is no clearing pass.
module overwriting_ring_with_offset_lookup (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // entry_handle[31:0], entry_size[47:32], lookup_offset[71:48]
  input  logic [orwol_pkg::IN_TDATA_W-1:0]    in_tdata,
  // mode
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // slot_index[3:0], found_handle[35:4], byte_offset[51:36], zero pad
  output logic [orwol_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // found
  output logic                                out_tuser
);

  orwol_pkg::mem_wr_t             mem_wr;
  orwol_pkg::idx_t                rd_addr;
  logic [orwol_pkg::HANDLE_W-1:0] rd_handle;
  logic [orwol_pkg::SIZE_W-1:0]   rd_size;
  logic                           res_valid;
  logic                           res_ready;
  orwol_pkg::res_t                res;
  logic                           out_valid_r;
  orwol_pkg::res_t                out_res_r;

  orwol_store u_store (
    .clk       (clk),
    .wr        (mem_wr),
    .rd_addr   (rd_addr),
    .rd_handle (rd_handle),
    .rd_size   (rd_size)
  );

  orwol_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_handle (in_tdata[31:0]),
    .in_size   (in_tdata[47:32]),
    .in_offset (in_tdata[71:48]),
    .mem_wr    (mem_wr),
    .rd_addr   (rd_addr),
    .rd_handle (rd_handle),
    .rd_size   (rd_size),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.found;
  assign out_tdata  = {4'b0, out_res_r.byte_offset, out_res_r.found_handle,
                       out_res_r.slot_index};

endmodule
